### hdl/crqs_pkg.sv
// Shared types and constants for the circular record queue with key search.
// Holds the queue depth, derived widths, opcodes, status codes and the record layout.
// Used by crqs_store and circular_record_queue_search; depends on nothing.
`default_nettype none

package crqs_pkg;

    // Queue geometry.
    localparam int DEPTH  = 8;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);

    // Field widths.
    localparam int OP_W    = 2;
    localparam int ST_W    = 2;
    localparam int KEY_W   = 16;
    localparam int CLS_W   = 8;
    localparam int GRADE_W = 7;

    localparam logic [CNT_W-1:0]   DEPTH_CNT = CNT_W'(DEPTH);
    localparam logic [ADDR_W-1:0]  LAST_SLOT = ADDR_W'(DEPTH - 1);
    localparam logic [GRADE_W-1:0] GRADE_MAX = 7'd100;

    typedef enum logic [OP_W-1:0] {
        OP_ENQ = 2'd0,
        OP_DEQ = 2'd1,
        OP_SEQ = 2'd2,
        OP_BIN = 2'd3
    } op_t;

    typedef enum logic [ST_W-1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_NOTFOUND = 2'd3
    } status_t;

    // One stored record, without its removed mark.
    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [CLS_W-1:0]   cls;
        logic [GRADE_W-1:0] grade;
    } rec_t;

    // Access request from the controller to the record store.
    typedef struct packed {
        logic              rec_we;
        logic              mark_we;
        logic [ADDR_W-1:0] waddr;
        rec_t              wrec;
        logic              wmark;
        logic [ADDR_W-1:0] raddr;
    } mem_req_t;

endpackage

`default_nettype wire

### hdl/crqs_store.sv
// Record store of the queue: a record memory and a removed-mark memory.
// One write port each, one shared read address, read data registered.
// Depends on crqs_pkg.
`default_nettype none

module crqs_store (
    input  wire logic              clk,
    input  wire crqs_pkg::mem_req_t req,
    output crqs_pkg::rec_t         rd_rec,
    output logic                   rd_mark
);

    crqs_pkg::rec_t rec_mem  [crqs_pkg::DEPTH];
    logic           mark_mem [crqs_pkg::DEPTH];

    // Record memory: write at the tail, registered read.
    always_ff @(posedge clk)
    begin
        if (req.rec_we)
        begin
            rec_mem[req.waddr] <= req.wrec;
        end
        rd_rec <= rec_mem[req.raddr];
    end

    // Removed marks: cleared on enqueue, set on dequeue, registered read.
    always_ff @(posedge clk)
    begin
        if (req.mark_we)
        begin
            mark_mem[req.waddr] <= req.wmark;
        end
        rd_mark <= mark_mem[req.raddr];
    end

endmodule

`default_nettype wire

### hdl/circular_record_queue_search.sv
// Circular record queue with sequential and binary key search.
// Enqueue and dequeue: result registered the cycle after the request.
// Sequential search: one memory read a cycle for each entry visited.
// Binary search: one bisection step per memory read.
// One request is in work at a time; the single read port of the store sets the search rate.
// Reset clears head, tail, count and handshake state; stored records are undefined until written.
`default_nettype none

module circular_record_queue_search (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [crqs_pkg::OP_W-1:0]     opcode,
    input  wire logic [crqs_pkg::KEY_W-1:0]    key_in,
    input  wire logic [crqs_pkg::CLS_W-1:0]    class_in,
    input  wire logic [crqs_pkg::GRADE_W-1:0]  grade_in,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [crqs_pkg::ST_W-1:0]          status,
    output logic [crqs_pkg::KEY_W-1:0]         key_out,
    output logic [crqs_pkg::CLS_W-1:0]         class_out,
    output logic [crqs_pkg::GRADE_W-1:0]       grade_out,
    output logic                               removed_out
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_DONE
    } state_t;

    state_t                         state_reg, state_next;
    logic [crqs_pkg::ADDR_W-1:0]    head_reg, head_next;
    logic [crqs_pkg::ADDR_W-1:0]    tail_reg, tail_next;
    logic [crqs_pkg::CNT_W-1:0]     count_reg, count_next;
    logic [crqs_pkg::ADDR_W-1:0]    idx_reg, idx_next;
    logic [crqs_pkg::CNT_W-1:0]     lo_reg, lo_next;
    logic [crqs_pkg::CNT_W-1:0]     hiex_reg, hiex_next;
    logic [crqs_pkg::KEY_W-1:0]     key_reg, key_next;
    crqs_pkg::op_t                  op_reg, op_next;
    crqs_pkg::status_t              res_status_reg, res_status_next;
    crqs_pkg::rec_t                 res_rec_reg, res_rec_next;
    logic                           res_mark_reg, res_mark_next;
    logic                           out_valid_reg, out_valid_next;
    crqs_pkg::status_t              out_status_reg, out_status_next;
    crqs_pkg::rec_t                 out_rec_reg, out_rec_next;
    logic                           out_mark_reg, out_mark_next;

    crqs_pkg::mem_req_t             mem_req;
    crqs_pkg::rec_t                 rd_rec;
    logic                           rd_mark;

    logic                           accept;
    logic                           out_free;
    logic [crqs_pkg::CNT_W-1:0]     seq_next_idx;
    logic [crqs_pkg::CNT_W-1:0]     bin_lo;
    logic [crqs_pkg::CNT_W-1:0]     bin_hiex;
    logic [crqs_pkg::CNT_W:0]       ring_sum;
    logic [crqs_pkg::ADDR_W-1:0]    ring_end;

    // Slot index plus one, wrapping at the last slot.
    function automatic logic [crqs_pkg::ADDR_W-1:0] inc_wrap(
        input logic [crqs_pkg::ADDR_W-1:0] a
    );
        if (a == crqs_pkg::LAST_SLOT)
        begin
            return '0;
        end
        return a + crqs_pkg::ADDR_W'(1);
    endfunction

    // Midpoint of the live range [lo, hiex), valid while lo < hiex.
    function automatic logic [crqs_pkg::ADDR_W-1:0] mid_of(
        input logic [crqs_pkg::CNT_W-1:0] lo,
        input logic [crqs_pkg::CNT_W-1:0] hiex
    );
        logic [crqs_pkg::CNT_W:0] s;
        s = {1'b0, lo} + {1'b0, hiex} - (crqs_pkg::CNT_W + 1)'(1);
        return crqs_pkg::ADDR_W'(s >> 1);
    endfunction

    crqs_store u_store (
        .clk     (clk),
        .req     (mem_req),
        .rd_rec  (rd_rec),
        .rd_mark (rd_mark)
    );

    // Handshake: one request at a time, and only when the result register can take it.
    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = (state_reg != S_IDLE) || !out_free;
    assign accept   = in_valid && !in_stall;

    // Search step helpers.
    assign seq_next_idx = crqs_pkg::CNT_W'(idx_reg) + crqs_pkg::CNT_W'(1);

    always_comb
    begin
        bin_lo   = lo_reg;
        bin_hiex = hiex_reg;
        if (key_reg < rd_rec.key)
        begin
            bin_hiex = crqs_pkg::CNT_W'(idx_reg);
        end
        else
        begin
            bin_lo = crqs_pkg::CNT_W'(idx_reg) + crqs_pkg::CNT_W'(1);
        end
    end

    // Controller: queue pointers, search walk and result staging.
    always_comb
    begin
        state_next      = state_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        lo_next         = lo_reg;
        hiex_next       = hiex_reg;
        key_next        = key_reg;
        op_next         = op_reg;
        res_status_next = res_status_reg;
        res_rec_next    = res_rec_reg;
        res_mark_next   = res_mark_reg;
        out_valid_next  = out_valid_reg && out_stall;
        out_status_next = out_status_reg;
        out_rec_next    = out_rec_reg;
        out_mark_next   = out_mark_reg;

        mem_req         = '0;
        mem_req.raddr   = idx_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    out_rec_next  = '0;
                    out_mark_next = 1'b0;
                    case (crqs_pkg::op_t'(opcode))
                        crqs_pkg::OP_ENQ:
                        begin
                            out_valid_next = 1'b1;
                            if (count_reg == crqs_pkg::DEPTH_CNT)
                            begin
                                out_status_next = crqs_pkg::ST_FULL;
                            end
                            else
                            begin
                                mem_req.rec_we     = 1'b1;
                                mem_req.mark_we    = 1'b1;
                                mem_req.waddr      = tail_reg;
                                mem_req.wrec.key   = key_in;
                                mem_req.wrec.cls   = class_in;
                                mem_req.wrec.grade = (grade_in > crqs_pkg::GRADE_MAX) ?
                                                     crqs_pkg::GRADE_MAX : grade_in;
                                mem_req.wmark      = 1'b0;
                                tail_next          = inc_wrap(tail_reg);
                                count_next         = count_reg + crqs_pkg::CNT_W'(1);
                                out_status_next    = crqs_pkg::ST_OK;
                            end
                        end
                        crqs_pkg::OP_DEQ:
                        begin
                            out_valid_next = 1'b1;
                            if (count_reg == '0)
                            begin
                                out_status_next = crqs_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                mem_req.mark_we = 1'b1;
                                mem_req.waddr   = head_reg;
                                mem_req.wmark   = 1'b1;
                                head_next       = inc_wrap(head_reg);
                                count_next      = count_reg - crqs_pkg::CNT_W'(1);
                                out_status_next = crqs_pkg::ST_OK;
                            end
                        end
                        crqs_pkg::OP_SEQ:
                        begin
                            if (count_reg == '0)
                            begin
                                out_valid_next  = 1'b1;
                                out_status_next = crqs_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                mem_req.raddr = '0;
                                idx_next      = '0;
                                key_next      = key_in;
                                op_next       = crqs_pkg::OP_SEQ;
                                state_next    = S_SEARCH;
                            end
                        end
                        crqs_pkg::OP_BIN:
                        begin
                            if (tail_reg == '0)
                            begin
                                out_valid_next  = 1'b1;
                                out_status_next = crqs_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                lo_next       = '0;
                                hiex_next     = crqs_pkg::CNT_W'(tail_reg);
                                mem_req.raddr = mid_of('0, crqs_pkg::CNT_W'(tail_reg));
                                idx_next      = mid_of('0, crqs_pkg::CNT_W'(tail_reg));
                                key_next      = key_in;
                                op_next       = crqs_pkg::OP_BIN;
                                state_next    = S_SEARCH;
                            end
                        end
                        default:
                        begin
                            out_valid_next  = 1'b1;
                            out_status_next = crqs_pkg::ST_EMPTY;
                        end
                    endcase
                end
            end

            // Read data holds the entry at idx_reg; compare and issue the next read.
            S_SEARCH:
            begin
                if (rd_rec.key == key_reg)
                begin
                    res_status_next = crqs_pkg::ST_OK;
                    res_rec_next    = rd_rec;
                    res_mark_next   = rd_mark;
                    state_next      = S_DONE;
                end
                else if (op_reg == crqs_pkg::OP_SEQ)
                begin
                    if (seq_next_idx < count_reg)
                    begin
                        idx_next      = crqs_pkg::ADDR_W'(seq_next_idx);
                        mem_req.raddr = crqs_pkg::ADDR_W'(seq_next_idx);
                    end
                    else
                    begin
                        res_status_next = crqs_pkg::ST_NOTFOUND;
                        res_rec_next    = '0;
                        res_mark_next   = 1'b0;
                        state_next      = S_DONE;
                    end
                end
                else
                begin
                    lo_next   = bin_lo;
                    hiex_next = bin_hiex;
                    if (bin_lo < bin_hiex)
                    begin
                        idx_next      = mid_of(bin_lo, bin_hiex);
                        mem_req.raddr = mid_of(bin_lo, bin_hiex);
                    end
                    else
                    begin
                        res_status_next = crqs_pkg::ST_NOTFOUND;
                        res_rec_next    = '0;
                        res_mark_next   = 1'b0;
                        state_next      = S_DONE;
                    end
                end
            end

            // Hand the search result to the output register once it is free.
            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_rec_next    = res_rec_reg;
                    out_mark_next   = res_mark_reg;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            head_reg       <= '0;
            tail_reg       <= '0;
            count_reg      <= '0;
            idx_reg        <= '0;
            lo_reg         <= '0;
            hiex_reg       <= '0;
            key_reg        <= '0;
            op_reg         <= crqs_pkg::OP_ENQ;
            res_status_reg <= crqs_pkg::ST_OK;
            res_rec_reg    <= '0;
            res_mark_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_status_reg <= crqs_pkg::ST_OK;
            out_rec_reg    <= '0;
            out_mark_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            head_reg       <= head_next;
            tail_reg       <= tail_next;
            count_reg      <= count_next;
            idx_reg        <= idx_next;
            lo_reg         <= lo_next;
            hiex_reg       <= hiex_next;
            key_reg        <= key_next;
            op_reg         <= op_next;
            res_status_reg <= res_status_next;
            res_rec_reg    <= res_rec_next;
            res_mark_reg   <= res_mark_next;
            out_valid_reg  <= out_valid_next;
            out_status_reg <= out_status_next;
            out_rec_reg    <= out_rec_next;
            out_mark_reg   <= out_mark_next;
        end
    end

    // Output ports.
    assign out_valid   = out_valid_reg;
    assign status      = out_status_reg;
    assign key_out     = out_rec_reg.key;
    assign class_out   = out_rec_reg.cls;
    assign grade_out   = out_rec_reg.grade;
    assign removed_out = out_mark_reg;

    // Expected tail: head advanced by the entry count, wrapping.
    always_comb
    begin
        ring_sum = (crqs_pkg::CNT_W + 1)'(head_reg) + (crqs_pkg::CNT_W + 1)'(count_reg);
        if (ring_sum >= (crqs_pkg::CNT_W + 1)'(crqs_pkg::DEPTH))
        begin
            ring_sum = ring_sum - (crqs_pkg::CNT_W + 1)'(crqs_pkg::DEPTH);
        end
        ring_end = crqs_pkg::ADDR_W'(ring_sum);
    end

    // The entry count never exceeds the queue depth.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= crqs_pkg::DEPTH_CNT)
        else $error("entry count above queue depth");

    // Head, tail and count stay consistent around the ring.
    a_ring_consistent: assert property (@(posedge clk) disable iff (!rst_n)
        tail_reg == ring_end)
        else $error("tail does not match head plus count");

    // An enqueue request on a queue with room adds exactly one entry.
    a_enq_count: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && opcode == crqs_pkg::OP_ENQ && count_reg != crqs_pkg::DEPTH_CNT)
        |=> (count_reg == $past(count_reg) + crqs_pkg::CNT_W'(1)))
        else $error("enqueue did not add one entry");

    // A finished search result is handed to the output register once that register is free.
    a_done_no_loss: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && out_free) |=> (out_valid_reg && state_reg == S_IDLE))
        else $error("search result not handed to output");

endmodule

`default_nettype wire
